@@ rtl/bq_iir_pkg.sv @@
// Shared types and constants for the biquad IIR filter.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package bq_iir_pkg;

  // Fixed field widths
  localparam int COEF_W    = 20;  // signed Q3.16 coefficient
  localparam int STATE_W   = 40;  // delay accumulator width
  localparam int CFG_IDX_W = 3;   // configuration register index

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF2 = 3'd4;

  // Coefficient reset values (unity pass-through)
  localparam logic signed [COEF_W-1:0] FF_COEF0_RST = 20'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_ZERO_RST = 20'sd0;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL0  = 8'b0000_0010,
    ST_ACC0  = 8'b0000_0100,
    ST_ROUND = 8'b0000_1000,
    ST_FB1   = 8'b0001_0000,
    ST_UPD1  = 8'b0010_0000,
    ST_FB2   = 8'b0100_0000,
    ST_UPD2  = 8'b1000_0000
  } state_e;

  // Operand selects for the shared adder
  typedef enum logic [1:0] {
    ADD_A_ACC  = 2'd0,
    ADD_A_D1   = 2'd1,
    ADD_A_D2   = 2'd2,
    ADD_A_ZERO = 2'd3
  } add_a_e;

endpackage

`default_nettype wire

@@ rtl/bq_iir_if.sv @@
// Valid/ready channel interfaces of the biquad IIR filter.
// Depends on bq_iir_pkg for the coefficient and index widths.
`default_nettype none

// Input sample channel
interface bq_sample_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// Filtered sample channel
interface bq_sample_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// Coefficient write channel
interface bq_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [bq_iir_pkg::CFG_IDX_W-1:0]       index;
  logic [bq_iir_pkg::COEF_W-1:0]          data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/biquad_iir_filter_top.sv @@
// Biquad IIR filter, transposed direct form II, one shared multiplier and adder.
// Depends on bq_iir_pkg and the channel interfaces in bq_iir_if.sv.
//
//   channel  dir  payload                      transaction when
//   in_i     in   sample_in                    in_i.valid  & in_i.ready
//   out_o    out  sample_out, clipped          out_o.valid & out_o.ready
//   cfg_i    in   index, data                  cfg_i.valid & cfg_i.ready
//
// Each sample passes through the accept cycle and then seven sequencer steps,
// set by the five products sharing one multiplier and the six sums sharing
// one adder; the next sample is taken only once the sequencer is idle again.
// Reset clears both delay states and loads the coefficients to unity gain.
// A result waits in the output register; the last step holds while it is
// still untaken. Coefficient writes are taken in every cycle.
`default_nettype none

module biquad_iir_filter_top #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  bq_sample_in_if.sink     in_i,
  bq_sample_out_if.source  out_o,
  bq_cfg_if.sink           cfg_i
);

  localparam int CW   = bq_iir_pkg::COEF_W;
  localparam int SW_ST = bq_iir_pkg::STATE_W;
  localparam int PW   = SAMPLE_WIDTH + CW;
  localparam int AW   = ((PW > SW_ST) ? PW : SW_ST) + 2;
  localparam logic [AW-1:0] RND_HALF = AW'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [SW_ST-1:0] ST_MAX = {1'b0, {(SW_ST-1){1'b1}}};
  localparam logic signed [SW_ST-1:0] ST_MIN = {1'b1, {(SW_ST-1){1'b0}}};

  bq_iir_pkg::state_e state_q, state_d;

  logic signed [CW-1:0]           coef_q [5];
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [SAMPLE_WIDTH-1:0] y_q;
  logic                           clip_q;
  logic signed [PW-1:0]           prod_q;
  logic signed [AW-1:0]           acc_q;
  logic signed [SW_ST-1:0]        d1_q;
  logic signed [SW_ST-1:0]        d2_q;
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic                           out_clip_q;

  logic in_fire, out_fire, step_go;

  // Multiplier and adder controls
  logic                           mul_en;
  logic                           mul_use_y;
  logic [2:0]                     coef_sel;
  logic signed [SAMPLE_WIDTH-1:0] mul_a;
  logic signed [CW-1:0]           mul_b;
  logic signed [PW-1:0]           mul_p;
  bq_iir_pkg::add_a_e             add_a_sel;
  logic                           add_use_prod;
  logic                           add_sub;
  logic signed [AW-1:0]           add_a, add_b, add_sum;
  logic                           state_sat_hi;
  logic signed [SW_ST-1:0]        add_sat;

  // Rounding and output saturation
  logic signed [AW-1:0]           rnd_sum, rnd_shift;
  logic                           y_ovf;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;

  assign in_i.ready  = (state_q == bq_iir_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_sample_q;
  assign out_o.clipped    = out_clip_q;

  // Hold the last step while a previous result is still untaken
  assign step_go = !((state_q == bq_iir_pkg::ST_UPD2) && out_valid_q && !out_o.ready);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    mul_en       = 1'b0;
    mul_use_y    = 1'b0;
    coef_sel     = bq_iir_pkg::REG_FF_COEF0;
    add_a_sel    = bq_iir_pkg::ADD_A_ACC;
    add_use_prod = 1'b1;
    add_sub      = 1'b0;
    case (state_q)
      bq_iir_pkg::ST_IDLE: begin
        if (in_fire) state_d = bq_iir_pkg::ST_MUL0;
      end
      bq_iir_pkg::ST_MUL0: begin
        mul_en       = 1'b1;
        add_a_sel    = bq_iir_pkg::ADD_A_D1;
        add_use_prod = 1'b0;
        state_d      = bq_iir_pkg::ST_ACC0;
      end
      bq_iir_pkg::ST_ACC0: begin
        mul_en   = 1'b1;
        coef_sel = bq_iir_pkg::REG_FF_COEF1;
        state_d  = bq_iir_pkg::ST_ROUND;
      end
      bq_iir_pkg::ST_ROUND: begin
        add_a_sel = bq_iir_pkg::ADD_A_D2;
        state_d   = bq_iir_pkg::ST_FB1;
      end
      bq_iir_pkg::ST_FB1: begin
        mul_en    = 1'b1;
        mul_use_y = 1'b1;
        coef_sel  = bq_iir_pkg::REG_FB_COEF1;
        state_d   = bq_iir_pkg::ST_UPD1;
      end
      bq_iir_pkg::ST_UPD1: begin
        mul_en   = 1'b1;
        coef_sel = bq_iir_pkg::REG_FF_COEF2;
        add_sub  = 1'b1;
        state_d  = bq_iir_pkg::ST_FB2;
      end
      bq_iir_pkg::ST_FB2: begin
        mul_en    = 1'b1;
        mul_use_y = 1'b1;
        coef_sel  = bq_iir_pkg::REG_FB_COEF2;
        add_a_sel = bq_iir_pkg::ADD_A_ZERO;
        state_d   = bq_iir_pkg::ST_UPD2;
      end
      bq_iir_pkg::ST_UPD2: begin
        add_sub = 1'b1;
        if (step_go) state_d = bq_iir_pkg::ST_IDLE;
      end
      default: state_d = bq_iir_pkg::ST_IDLE;
    endcase
  end

  // Shared multiplier
  assign mul_a = mul_use_y ? y_q : x_q;
  always_comb begin
    case (coef_sel)
      bq_iir_pkg::REG_FF_COEF0: mul_b = coef_q[0];
      bq_iir_pkg::REG_FF_COEF1: mul_b = coef_q[1];
      bq_iir_pkg::REG_FF_COEF2: mul_b = coef_q[2];
      bq_iir_pkg::REG_FB_COEF1: mul_b = coef_q[3];
      bq_iir_pkg::REG_FB_COEF2: mul_b = coef_q[4];
      default:                  mul_b = coef_q[0];
    endcase
  end
  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // Shared adder with 40-bit state saturation
  always_comb begin
    case (add_a_sel)
      bq_iir_pkg::ADD_A_ACC:  add_a = acc_q;
      bq_iir_pkg::ADD_A_D1:   add_a = AW'(d1_q);
      bq_iir_pkg::ADD_A_D2:   add_a = AW'(d2_q);
      bq_iir_pkg::ADD_A_ZERO: add_a = '0;
      default:                add_a = acc_q;
    endcase
  end
  assign add_b   = add_use_prod ? AW'(prod_q) : '0;
  assign add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
  assign state_sat_hi = (&add_sum[AW-1:SW_ST-1]) || !(|add_sum[AW-1:SW_ST-1]);
  assign add_sat = state_sat_hi ? add_sum[SW_ST-1:0]
                 : (add_sum[AW-1] ? ST_MIN : ST_MAX);

  // Round half up, then saturate to the sample width
  assign rnd_sum   = acc_q + $signed(RND_HALF);
  assign rnd_shift = rnd_sum >>> COEF_FRAC_BITS;
  assign y_ovf = !((&rnd_shift[AW-1:SAMPLE_WIDTH-1]) || !(|rnd_shift[AW-1:SAMPLE_WIDTH-1]));
  assign y_sat = y_ovf ? (rnd_shift[AW-1] ? Y_MIN : Y_MAX) : rnd_shift[SAMPLE_WIDTH-1:0];

  // Control state, coefficients and delay states
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bq_iir_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
      coef_q[0]   <= bq_iir_pkg::FF_COEF0_RST;
      coef_q[1]   <= bq_iir_pkg::COEF_ZERO_RST;
      coef_q[2]   <= bq_iir_pkg::COEF_ZERO_RST;
      coef_q[3]   <= bq_iir_pkg::COEF_ZERO_RST;
      coef_q[4]   <= bq_iir_pkg::COEF_ZERO_RST;
    end else begin
      state_q <= state_d;
      if (state_q == bq_iir_pkg::ST_UPD1) d1_q <= add_sat;
      if ((state_q == bq_iir_pkg::ST_UPD2) && step_go) begin
        d2_q        <= add_sat;
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      // Write a coefficient; drop indexes past the list
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          bq_iir_pkg::REG_FF_COEF0: coef_q[0] <= cfg_i.data;
          bq_iir_pkg::REG_FF_COEF1: coef_q[1] <= cfg_i.data;
          bq_iir_pkg::REG_FF_COEF2: coef_q[2] <= cfg_i.data;
          bq_iir_pkg::REG_FB_COEF1: coef_q[3] <= cfg_i.data;
          bq_iir_pkg::REG_FB_COEF2: coef_q[4] <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) x_q <= in_i.sample_in;
    if (mul_en) prod_q <= mul_p;
    if (state_q == bq_iir_pkg::ST_ROUND) begin
      y_q    <= y_sat;
      clip_q <= y_ovf;
    end
    if ((state_q == bq_iir_pkg::ST_MUL0) || (state_q == bq_iir_pkg::ST_ACC0) ||
        (state_q == bq_iir_pkg::ST_ROUND) || (state_q == bq_iir_pkg::ST_FB2)) begin
      acc_q <= add_sum;
    end
    if ((state_q == bq_iir_pkg::ST_UPD2) && step_go) begin
      out_sample_q <= y_q;
      out_clip_q   <= clip_q;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted sample starts the sequence in the next cycle
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == bq_iir_pkg::ST_MUL0))
    else $error("sequence did not start after input transaction");

  // A new result appears only out of the last step
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == bq_iir_pkg::ST_UPD2))
    else $error("result raised outside the last step");

  // A clipped result sits at a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_clip_q) |-> ((out_sample_q == Y_MAX) || (out_sample_q == Y_MIN)))
    else $error("clipped flag set off the rails");

  // A waiting result is never overwritten by the next one
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready && (state_q == bq_iir_pkg::ST_UPD2))
      |=> (state_q == bq_iir_pkg::ST_UPD2))
    else $error("last step left while the result was untaken");
`endif

endmodule

`default_nettype wire

@@ tb/tb_biquad_iir_filter_top.sv @@
// Self-checking testbench for the biquad IIR filter top level.
// Depends on bq_iir_pkg, the channel interfaces in bq_iir_if.sv and biquad_iir_filter_top.
`timescale 1ns / 100ps

module tb_biquad_iir_filter_top;

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_REGS    = 5;
  localparam int COEF_W      = bq_iir_pkg::COEF_W;
  localparam int STATE_W     = bq_iir_pkg::STATE_W;
  localparam int IDX_W       = bq_iir_pkg::CFG_IDX_W;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES  = 9;
  localparam int SETTLE_CYC  = 16;        // idle wait after the last output, for the sequencer to finish
  localparam longint TIMEOUT_NS = 5_000_000;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_HALF = 20'sd32768;

  typedef enum int {COEF_FULL, COEF_SMALL, COEF_ALL_MAX, COEF_ALL_MIN} coef_mode_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } filt_result_t;

  // Filter predictor and store of expected filtered samples
  class biquad_scoreboard;
    longint coef[NUM_REGS];
    longint delay_one;
    longint delay_two;
    filt_result_t expected_q[$];
    int errors;

    function new();
      coef[0]   = longint'(bq_iir_pkg::FF_COEF0_RST);
      for (int i = 1; i < NUM_REGS; i++) coef[i] = longint'(bq_iir_pkg::COEF_ZERO_RST);
      delay_one = 0;
      delay_two = 0;
      errors    = 0;
    endfunction

    function longint clamp_state(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (STATE_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // Update a coefficient; indexes past the last register are dropped
    function void write_coef(logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] value);
      if (idx <= bq_iir_pkg::REG_FB_COEF2) coef[idx] = longint'(value);
    endfunction

    // Run one sample through the filter and queue the expected output
    function void note_sample(logic signed [SAMPLE_W-1:0] x);
      longint xs;
      longint acc;
      longint y;
      filt_result_t res;
      xs = longint'(x);
      acc = xs * coef[bq_iir_pkg::REG_FF_COEF0] + delay_one;
      y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      res.clipped = 1'b0;
      if (y > longint'(SAMPLE_MAX)) begin
        y = longint'(SAMPLE_MAX);
        res.clipped = 1'b1;
      end else if (y < longint'(SAMPLE_MIN)) begin
        y = longint'(SAMPLE_MIN);
        res.clipped = 1'b1;
      end
      res.sample_out = y[SAMPLE_W-1:0];
      delay_one = clamp_state(xs * coef[bq_iir_pkg::REG_FF_COEF1] + delay_two
                              - coef[bq_iir_pkg::REG_FB_COEF1] * y);
      delay_two = clamp_state(xs * coef[bq_iir_pkg::REG_FF_COEF2]
                              - coef[bq_iir_pkg::REG_FB_COEF2] * y);
      expected_q.push_back(res);
    endfunction

    // Compare one filtered sample with the oldest expectation
    function void check_result(logic signed [SAMPLE_W-1:0] y, logic clip);
      filt_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output transaction, actual sample_out %0d clipped %0b",
                 $time, y, clip);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (y !== exp_res.sample_out) begin
        $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                 $time, exp_res.sample_out, y);
        errors++;
      end
      if (clip !== exp_res.clipped) begin
        $display("%0t: clipped mismatch, expected %0b, actual %0b",
                 $time, exp_res.clipped, clip);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   tx_idle_pct;
  int   rx_idle_pct;
  biquad_scoreboard sb;

  bq_sample_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) in_if ();
  bq_sample_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) out_if ();
  bq_cfg_if cfg_if ();

  biquad_iir_filter_top #(
    .SAMPLE_WIDTH  (SAMPLE_W),
    .COEF_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Random backpressure on the output channel
  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(99) >= rx_idle_pct);
  end

  // Watch all three channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.sample_out, out_if.clipped);
      if (cfg_if.valid && cfg_if.ready) sb.write_coef(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) sb.note_sample(in_if.sample_in);
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Send one sample, with random idle cycles ahead of it
  task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.sample_in = x;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Drop valid, wait for every expected output, then let the sequencer finish
  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] s;
    if ($urandom_range(15) == 0) return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    s = SAMPLE_W'($urandom());
    return s;
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(coef_mode_e mode);
    logic [COEF_W-1:0] c;
    case (mode)
      COEF_ALL_MAX: c = COEF_MAX;
      COEF_ALL_MIN: c = COEF_MIN;
      COEF_SMALL:   c = COEF_W'($urandom_range(131072) - 65536);
      default:      c = COEF_W'($urandom());
    endcase
    return c;
  endfunction

  // Load all five coefficients, sometimes with a stray out-of-range write
  task automatic load_filter(coef_mode_e mode);
    if ($urandom_range(1)) begin
      write_reg(IDX_W'(bq_iir_pkg::REG_FB_COEF2 + 1 + $urandom_range(2)),
                COEF_W'($urandom()));
    end
    for (int i = 0; i < NUM_REGS; i++) write_reg(IDX_W'(i), pick_coef(mode));
  endtask

  // Main sequence
  initial begin
    coef_mode_e mode;
    sb = new();
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    tx_idle_pct     = 34;
    rx_idle_pct     = 81;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Unity gain from reset: sample extremes pass straight through
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample(SAMPLE_W'(1));
    send_sample(SAMPLE_W'(-1));
    drain();

    // Half gain: rounding ties go upward on both signs
    write_reg(bq_iir_pkg::REG_FF_COEF0, COEF_HALF);
    send_sample(SAMPLE_W'(1));
    send_sample(SAMPLE_W'(-1));
    send_sample(SAMPLE_W'(3));
    send_sample(SAMPLE_W'(-3));
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    drain();

    // Extreme coefficients: saturation both ways, feedback, ignored indexes
    write_reg(bq_iir_pkg::REG_FF_COEF0, COEF_MAX);
    write_reg(bq_iir_pkg::REG_FF_COEF1, COEF_MIN);
    write_reg(bq_iir_pkg::REG_FF_COEF2, COEF_MAX);
    write_reg(bq_iir_pkg::REG_FB_COEF1, COEF_MIN);
    write_reg(bq_iir_pkg::REG_FB_COEF2, COEF_MAX);
    for (int i = bq_iir_pkg::REG_FB_COEF2 + 1; i < (1 << IDX_W); i++) begin
      write_reg(IDX_W'(i), COEF_HALF);
    end
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_W'(100));
    send_sample(SAMPLE_W'(-100));
    send_sample('0);
    drain();

    // Random phases, each with its own coefficient set; idling profile per group of three
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        tx_idle_pct = 34;
        rx_idle_pct = 81;
      end else if (p < 6) begin
        tx_idle_pct = 81;
        rx_idle_pct = 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 1)          mode = COEF_ALL_MAX;
      else if (p == 4)     mode = COEF_ALL_MIN;
      else if (p % 2 == 0) mode = COEF_SMALL;
      else                 mode = COEF_FULL;
      load_filter(mode);
      repeat (PHASE_ITEMS) send_sample(pick_sample());
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ biquad_iir_filter_top.f @@
rtl/bq_iir_pkg.sv
rtl/bq_iir_if.sv
rtl/biquad_iir_filter_top.sv
tb/tb_biquad_iir_filter_top.sv
